// ===== rtl/core/hte_pkg.sv =====
// ----------------------------------------------------------------------------
// hte_pkg
// Shared constants and types of the static-table Huffman encoder.
// ----------------------------------------------------------------------------
package hte_pkg;

   localparam int SYMBOL_COUNT = 256;
   localparam int MAX_CODE_LEN = 32;

   localparam int SYM_W  = 8;
   localparam int LEN_W  = 6;
   localparam int CODE_W = 32;
   localparam int BYTE_W = 8;
   localparam int ADDR_W = $clog2(SYMBOL_COUNT);
   localparam int CAP_LEN = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
   localparam int BUF_W  = CODE_W + BYTE_W;
   localparam int CNT_W  = $clog2(BUF_W);

   localparam logic [1:0] MODE_LOAD   = 2'd0;
   localparam logic [1:0] MODE_ENCODE = 2'd1;
   localparam logic [1:0] MODE_FLUSH  = 2'd2;

   typedef struct packed {
      logic [LEN_W-1:0]  len;
      logic [CODE_W-1:0] bits;
   } entry_type;

   typedef struct packed {
      logic [1:0] mode;
      entry_type  entry;
   } item_type;

endpackage

// ===== rtl/core/hte_table.sv =====
// ----------------------------------------------------------------------------
// hte_table
// Code table memory with per-entry valid bits and the lookup stage register.
// ----------------------------------------------------------------------------
module hte_table (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_mode,
   input  logic [hte_pkg::SYM_W-1:0] req_symbol,
   input  logic [hte_pkg::LEN_W-1:0] req_code_length,
   input  logic [hte_pkg::CODE_W-1:0] req_code_value,
   output logic                      item_valid,
   output hte_pkg::item_type         item,
   input  logic                      item_take
);
   import hte_pkg::*;

   entry_type              mem [SYMBOL_COUNT];
   logic                   valid_ff [SYMBOL_COUNT];
   entry_type              rd_ff;
   logic                   rdv_ff;
   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   logic [1:0]             s1_mode_ff;
   logic                   accept;
   logic                   sym_ok;
   logic                   wr_en;
   logic [ADDR_W-1:0]      addr;
   logic [LEN_W-1:0]       len_sat;

   assign req_ready = !s1_valid_ff || item_take;
   assign accept    = req_valid && req_ready;
   assign sym_ok    = ((SYM_W+1)'(req_symbol) < (SYM_W+1)'(SYMBOL_COUNT));
   assign addr      = req_symbol[ADDR_W-1:0];
   assign wr_en     = accept && (req_mode == MODE_LOAD) && sym_ok;
   assign len_sat   = (req_code_length > LEN_W'(CAP_LEN)) ? LEN_W'(CAP_LEN)
                                                          : req_code_length;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= '{len: len_sat, bits: req_code_value};
      end
      if (accept) begin
         rd_ff      <= mem[addr];
         s1_mode_ff <= req_mode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SYMBOL_COUNT; i++) begin
            valid_ff[i] <= 1'b0;
         end
         rdv_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[addr] <= 1'b1;
         end
         if (accept) begin
            rdv_ff <= valid_ff[addr] && sym_ok;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (item_take) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   assign item_valid      = s1_valid_ff;
   assign item.mode       = s1_mode_ff;
   assign item.entry.len  = rdv_ff ? rd_ff.len : '0;
   assign item.entry.bits = rd_ff.bits;

endmodule

// ===== rtl/core/hte_packer.sv =====
// ----------------------------------------------------------------------------
// hte_packer
// Bit packer: merges code bits into a left-aligned buffer and emits bytes
// MSB first through the output register.
// ----------------------------------------------------------------------------
module hte_packer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       item_valid,
   input  hte_pkg::item_type          item,
   output logic                       item_take,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [hte_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic                       rsp_last_of_run,
   output logic                       rsp_end_of_stream
);
   import hte_pkg::*;

   logic [BUF_W-1:0]  buf_ff, buf_in, buf_after;
   logic [CNT_W-1:0]  cnt_ff, cnt_in, cnt_after;
   logic              flush_ff, flush_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_eos_ff, rsp_eos_in;
   logic              out_take;
   logic              busy;
   logic              emit;
   logic              free;
   logic              passive;
   logic [CNT_W-1:0]  shamt;
   logic [CODE_W-1:0] aligned;

   assign out_take  = !rsp_valid_ff || rsp_ready;
   assign busy      = flush_ff || (cnt_ff >= CNT_W'(BYTE_W));
   assign emit      = busy && out_take;
   assign free      = !busy || (emit && (flush_ff || (cnt_ff < CNT_W'(2 * BYTE_W))));
   assign passive   = (item.mode != MODE_ENCODE) && (item.mode != MODE_FLUSH);
   assign item_take = item_valid && (passive || free);

   assign shamt   = CNT_W'(CODE_W) - CNT_W'(item.entry.len);
   assign aligned = (item.entry.len == '0) ? '0
                                           : (item.entry.bits << shamt[$clog2(CODE_W)-1:0]);

   always_comb begin
      buf_after = buf_ff;
      cnt_after = cnt_ff;
      if (emit) begin
         if (flush_ff) begin
            buf_after = '0;
            cnt_after = '0;
         end else begin
            buf_after = buf_ff << BYTE_W;
            cnt_after = cnt_ff - CNT_W'(BYTE_W);
         end
      end
   end

   always_comb begin
      buf_in   = buf_after;
      cnt_in   = cnt_after;
      flush_in = flush_ff && !emit;
      if (item_take && (item.mode == MODE_ENCODE)) begin
         buf_in = buf_after | ({aligned, BYTE_W'(0)} >> cnt_after[$clog2(BYTE_W)-1:0]);
         cnt_in = cnt_after + CNT_W'(item.entry.len);
      end else if (item_take && (item.mode == MODE_FLUSH)) begin
         flush_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_eos_in   = rsp_eos_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = buf_ff[BUF_W-1 -: BYTE_W];
         rsp_last_in  = flush_ff || (cnt_ff < CNT_W'(2 * BYTE_W));
         rsp_eos_in   = flush_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff       <= '0;
         cnt_ff       <= '0;
         flush_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         buf_ff       <= buf_in;
         cnt_ff       <= cnt_in;
         flush_ff     <= flush_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_eos_ff  <= rsp_eos_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = rsp_byte_ff;
   assign rsp_last_of_run   = rsp_last_ff;
   assign rsp_end_of_stream = rsp_eos_ff;

endmodule

// ===== rtl/core/huffman_table_encoder_core.sv =====
// ----------------------------------------------------------------------------
// huffman_table_encoder_core
// Static-table Huffman encoder with MSB-first byte packing.
//
// The req channel carries one item per transfer: mode load writes a table
// entry, mode encode appends the symbol's code bits, mode flush pads the
// partial byte and always yields one byte marked end_of_stream.
// The rsp channel carries one packed byte per transfer; last_of_run marks the
// final byte caused by an item.
// An item's first byte passes, in order, the table read register, the merge
// into the packer buffer and the output register; a stall can hold it
// at each of them.
// Throughput: one item per cycle while items yield at most one byte and the
// receiver keeps rsp_ready high; an encode yielding more bytes holds off the
// next item while the one-byte-per-cycle output drains them, so 32-bit codes are paced by the output.
// Reset clears all table lengths at once (valid bits), empties the packer
// and the output register; no clearing pass is needed.
// A stalled receiver holds the output register and backs up through the
// packer and the lookup stage to req_ready.
// ----------------------------------------------------------------------------
module huffman_table_encoder_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_mode,
   input  logic [hte_pkg::SYM_W-1:0]   req_symbol,
   input  logic [hte_pkg::LEN_W-1:0]   req_code_length,
   input  logic [hte_pkg::CODE_W-1:0]  req_code_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [hte_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                        rsp_last_of_run,
   output logic                        rsp_end_of_stream
);
   import hte_pkg::*;

   logic     item_valid;
   item_type item;
   logic     item_take;

   hte_table u_table (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_symbol      (req_symbol),
      .req_code_length (req_code_length),
      .req_code_value  (req_code_value),
      .item_valid      (item_valid),
      .item            (item),
      .item_take       (item_take)
   );

   hte_packer u_packer (
      .clock             (clock),
      .reset             (reset),
      .item_valid        (item_valid),
      .item              (item),
      .item_take         (item_take),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_end_of_stream (rsp_end_of_stream)
   );

endmodule

// ===== tb/hte_output_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hte_output_checker
// Watches both channels of the static-table Huffman encoder, keeps its own
// copy of the code table and the bit packer, and queues the bytes every
// request transfer must produce. Each response transfer is checked against
// the oldest queued byte, field by field. Mismatch and outstanding-byte
// counts go back to the testbench top.
// ----------------------------------------------------------------------------
module hte_output_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [1:0]                  req_mode,
   input  logic [hte_pkg::SYM_W-1:0]   req_symbol,
   input  logic [hte_pkg::LEN_W-1:0]   req_code_length,
   input  logic [hte_pkg::CODE_W-1:0]  req_code_value,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [hte_pkg::BYTE_W-1:0]  rsp_out_byte,
   input  logic                        rsp_last_of_run,
   input  logic                        rsp_end_of_stream,
   output int                          mismatch_count,
   output int                          bytes_owed
);

   import hte_pkg::*;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [BYTE_W-1:0] value;
      logic              last_of_run;
      logic              end_of_stream;
   } coded_byte_type;

   logic [LEN_W-1:0]  code_len_tbl  [SYMBOL_COUNT];
   logic [CODE_W-1:0] code_bits_tbl [SYMBOL_COUNT];
   logic [BYTE_W-1:0] partial_byte;
   int                partial_fill;
   coded_byte_type    expected_bytes[$];
   int                mismatches = 0;

   task automatic predict_packed_bytes(input logic [1:0]        mode,
                                       input logic [SYM_W-1:0]  sym,
                                       input logic [LEN_W-1:0]  len,
                                       input logic [CODE_W-1:0] val);
      int                n_bits;
      int                n_bytes;
      int                made;
      logic [BYTE_W-1:0] pad_byte;
      n_bits = 0;
      made   = 0;
      unique case (mode)
         MODE_LOAD: begin
            if (int'(sym) < SYMBOL_COUNT) begin
               n_bits = (int'(len) > MAX_CODE_LEN) ? MAX_CODE_LEN : int'(len);
               if (n_bits > CODE_W) n_bits = CODE_W;
               code_len_tbl[sym]  = LEN_W'(n_bits);
               code_bits_tbl[sym] = val;
            end
         end
         MODE_ENCODE: begin
            if (int'(sym) < SYMBOL_COUNT) n_bits = int'(code_len_tbl[sym]);
            n_bytes = (partial_fill + n_bits) / BYTE_W;
            for (int i = n_bits - 1; i >= 0; i--) begin
               partial_byte = {partial_byte[BYTE_W-2:0], code_bits_tbl[sym][i]};
               partial_fill++;
               if (partial_fill == BYTE_W) begin
                  expected_bytes.push_back('{value: partial_byte,
                                             last_of_run: (made == n_bytes - 1),
                                             end_of_stream: 1'b0});
                  made++;
                  partial_byte = '0;
                  partial_fill = 0;
               end
            end
         end
         MODE_FLUSH: begin
            pad_byte = '0;
            if (partial_fill != 0) pad_byte = partial_byte << (BYTE_W - partial_fill);
            expected_bytes.push_back('{value: pad_byte, last_of_run: 1'b1,
                                       end_of_stream: 1'b1});
            partial_byte = '0;
            partial_fill = 0;
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      coded_byte_type want;
      if (reset) begin
         foreach (code_len_tbl[s]) begin
            code_len_tbl[s]  = '0;
            code_bits_tbl[s] = '0;
         end
         partial_byte = '0;
         partial_fill = 0;
         expected_bytes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: unexpected transfer: byte=%02h last=%0b eos=%0b",
                           $realtime, rsp_out_byte, rsp_last_of_run, rsp_end_of_stream);
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want.value || rsp_last_of_run !== want.last_of_run ||
                   rsp_end_of_stream !== want.end_of_stream) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("%0t: mismatch: expected byte=%02h last=%0b eos=%0b, %s",
                              $realtime, want.value, want.last_of_run, want.end_of_stream,
                              $sformatf("got byte=%02h last=%0b eos=%0b",
                                        rsp_out_byte, rsp_last_of_run, rsp_end_of_stream));
               end
            end
         end
         if (req_valid && req_ready)
            predict_packed_bytes(req_mode, req_symbol, req_code_length, req_code_value);
      end
      mismatch_count <= mismatches;
      bytes_owed     <= expected_bytes.size();
   end

endmodule

// ===== tb/tb_huffman_table_encoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_huffman_table_encoder_core
// Stimulus and verdict for the static-table Huffman encoder.
//
// A directed run covers code-length extremes, saturation of long codes,
// unloaded and zero-length symbols, multi-byte codes, padded and empty
// flushes and the unused mode. A random run then mixes table loads, encodes
// of mostly loaded symbols and flushes under bursty idling on both channels, with
// one long receiver hold-off to back the block up. Checking is done by
// hte_output_checker; a watchdog ends a run that stops making progress.
// ----------------------------------------------------------------------------
module tb_huffman_table_encoder_core;

   import hte_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 125;
   localparam int CALM_ITEMS   = 40;
   localparam int HOLD_CYCLES  = 120;
   localparam int STALL_LIMIT  = 1000;
   localparam int TAIL_CYCLES  = 12;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_mode;
   logic [SYM_W-1:0]   req_symbol;
   logic [LEN_W-1:0]   req_code_length;
   logic [CODE_W-1:0]  req_code_value;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [BYTE_W-1:0]  rsp_out_byte;
   logic               rsp_last_of_run;
   logic               rsp_end_of_stream;
   int                 mismatch_count;
   int                 bytes_owed;

   bit                 quiet        = 1'b1;
   bit                 hold_pending = 1'b0;
   int                 idle_cycles  = 0;
   logic [SYM_W-1:0]   loaded_syms[$];

   huffman_table_encoder_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_symbol        (req_symbol),
      .req_code_length   (req_code_length),
      .req_code_value    (req_code_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_end_of_stream (rsp_end_of_stream)
   );

   hte_output_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_symbol        (req_symbol),
      .req_code_length   (req_code_length),
      .req_code_value    (req_code_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_end_of_stream (rsp_end_of_stream),
      .mismatch_count    (mismatch_count),
      .bytes_owed        (bytes_owed)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic offer_item(input logic [1:0]        mode,
                             input logic [SYM_W-1:0]  sym,
                             input logic [LEN_W-1:0]  len,
                             input logic [CODE_W-1:0] val);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_symbol      <= sym;
      req_code_length <= len;
      req_code_value  <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // receiver: bursty ready, one long hold-off when asked
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      rsp_ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_pending && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (quiet || $urandom_range(0, 2) != 0) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int               sent;
      int               pick;
      logic [1:0]       mode;
      logic [SYM_W-1:0] sym;
      logic [LEN_W-1:0] len;
      logic [CODE_W-1:0] val;

      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_mode        <= MODE_LOAD;
      req_symbol      <= '0;
      req_code_length <= '0;
      req_code_value  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      offer_item(MODE_ENCODE, 8'h00, 6'd0, 32'h0);
      offer_item(MODE_FLUSH, 8'h00, 6'd0, 32'h0);
      offer_item(MODE_LOAD, 8'h00, 6'd32, 32'hFFFF_FFFF);
      offer_item(MODE_LOAD, 8'hFF, 6'd63, 32'hA5A5_A5A5);
      offer_item(MODE_LOAD, 8'h01, 6'd1, 32'h0000_0001);
      offer_item(MODE_LOAD, 8'h02, 6'd7, 32'h0000_0000);
      offer_item(MODE_LOAD, 8'h03, 6'd0, 32'hDEAD_BEEF);
      offer_item(MODE_LOAD, 8'h80, 6'd40, 32'h1234_5678);
      offer_item(MODE_LOAD, 8'h04, 6'd8, 32'h0000_005A);
      offer_item(MODE_ENCODE, 8'h00, 6'd0, 32'h0);
      offer_item(MODE_ENCODE, 8'hFF, 6'd0, 32'h0);
      offer_item(MODE_ENCODE, 8'h01, 6'd0, 32'h0);
      offer_item(MODE_ENCODE, 8'h02, 6'd0, 32'h0);
      offer_item(MODE_ENCODE, 8'h03, 6'd0, 32'h0);
      offer_item(MODE_ENCODE, 8'h04, 6'd0, 32'h0);
      offer_item(MODE_ENCODE, 8'h01, 6'd0, 32'h0);
      offer_item(MODE_FLUSH, 8'h00, 6'd0, 32'h0);
      offer_item(MODE_UNUSED, 8'hFF, 6'd63, 32'hFFFF_FFFF);
      offer_item(MODE_ENCODE, 8'h80, 6'd0, 32'h0);
      offer_item(MODE_ENCODE, 8'h01, 6'd0, 32'h0);
      offer_item(MODE_ENCODE, 8'h00, 6'd0, 32'h0);
      offer_item(MODE_FLUSH, 8'h00, 6'd0, 32'h0);
      offer_item(MODE_FLUSH, 8'h00, 6'd0, 32'h0);
      loaded_syms = '{8'h00, 8'hFF, 8'h01, 8'h02, 8'h03, 8'h80, 8'h04};

      quiet        = 1'b0;
      hold_pending = 1'b1;
      sent         = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent == RANDOM_ITEMS - CALM_ITEMS) quiet = 1'b1;
         pick = $urandom_range(0, 99);
         sym  = SYM_W'($urandom);
         len  = LEN_W'($urandom);
         val  = $urandom;
         if (pick < 25) begin
            mode = MODE_LOAD;
            if ($urandom_range(0, 7) == 0) len = LEN_W'($urandom_range(0, 63));
            else len = LEN_W'($urandom_range(1, 12));
            if ($urandom_range(0, 3) == 0)
               sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
            loaded_syms.push_back(sym);
         end else if (pick < 85) begin
            mode = MODE_ENCODE;
            if ($urandom_range(0, 4) != 0)
               sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
         end else if (pick < 97) begin
            mode = MODE_FLUSH;
         end else begin
            mode = MODE_UNUSED;
         end
         offer_item(mode, sym, len, val);
         if (mode != MODE_UNUSED) sent++;
      end
      offer_item(MODE_FLUSH, 8'h00, 6'd0, 32'h0);

      req_valid <= 1'b0;
      @(posedge clock);
      while (bytes_owed != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
